// ----- hw/rtl/matrix_vector_transform_macros.svh -----
// Assertion macros used by the matrix vector transform top level.
`ifndef MATRIX_VECTOR_TRANSFORM_MACROS_SVH
`define MATRIX_VECTOR_TRANSFORM_MACROS_SVH
`ifndef SYNTH
// Checks a property on every rising edge of clk_i while rst_ni is high.
`define MVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checks that cons holds in the cycle after ante.
`define MVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MVT_ASSERT(lbl, prop, msg)
`define MVT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/mvt_pkg.sv -----
// Types and constants shared by the matrix vector transform modules.
`default_nettype none
package mvt_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;

  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + $clog2(DIM) + 1;
  localparam int COL_W  = 2;
  localparam int IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int ELEM_N = 4;

  localparam logic [DATA_W-1:0] FIX_ONE    = DATA_W'(1) << FRAC_BITS;
  localparam logic [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [DATA_W-1:0] SAT_MAX    = {1'b0, {(DATA_W - 1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN    = {1'b1, {(DATA_W - 1){1'b0}}};

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_XFORM = 1'b1
  } mode_e;

  typedef logic [DIM-1:0][DATA_W-1:0] vec_t;
  typedef logic [DIM-1:0][ACC_W-1:0]  acc_vec_t;

  // One transaction as it travels down the cell chain.
  typedef struct packed {
    mode_e            mode;
    logic [COL_W-1:0] col_idx;
    vec_t             vec;
    acc_vec_t         acc;
  } pipe_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mvt_cell.sv -----
// One column cell: holds a matrix column, multiplies and accumulates its share.
`default_nettype none
module mvt_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [mvt_pkg::IDX_W-1:0]  cell_idx_i,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  mvt_pkg::pipe_t             item_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output mvt_pkg::pipe_t             item_o
);
  import mvt_pkg::*;

  vec_t                     col_q;
  logic                     mul_valid_q, acc_valid_q;
  pipe_t                    mul_item_q, acc_item_q, acc_item_d;
  logic signed [PROD_W-1:0] prod_q [DIM];
  logic                     mul_adv, acc_adv, col_wr;
  logic [DATA_W-1:0]        vec_elem;

  assign acc_adv  = !acc_valid_q || ready_i;
  assign mul_adv  = !mul_valid_q || acc_adv;
  assign ready_o  = mul_adv;
  assign vec_elem = item_i.vec[cell_idx_i];

  // Loads travel in order with transforms, so each cell sees its column
  // change exactly between the transactions that came before and after it.
  assign col_wr = valid_i && mul_adv && (item_i.mode == MODE_LOAD) &&
                  (item_i.col_idx == COL_W'(cell_idx_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < DIM; r++) begin
        col_q[r] <= (cell_idx_i == IDX_W'(r)) ? FIX_ONE : '0;
      end
    end else if (col_wr) begin
      col_q <= item_i.vec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      acc_valid_q <= 1'b0;
    end else begin
      if (mul_adv) mul_valid_q <= valid_i;
      if (acc_adv) acc_valid_q <= mul_valid_q;
    end
  end

  always_comb begin
    acc_item_d = mul_item_q;
    for (int r = 0; r < DIM; r++) begin
      acc_item_d.acc[r] = mul_item_q.acc[r] +
                          {{(ACC_W - PROD_W){prod_q[r][PROD_W-1]}}, prod_q[r]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_adv) begin
      mul_item_q <= item_i;
      for (int r = 0; r < DIM; r++) begin
        prod_q[r] <= $signed(col_q[r]) * $signed(vec_elem);
      end
    end
    if (acc_adv) begin
      acc_item_q <= acc_item_d;
    end
  end

  assign valid_o = acc_valid_q;
  assign item_o  = acc_item_q;

endmodule
`default_nettype wire

// ----- hw/rtl/mvt_round.sv -----
// Rounding, scaling and saturation of the row sums into the output register.
`default_nettype none
module mvt_round (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  mvt_pkg::pipe_t item_i,
  output logic           valid_o,
  input  logic           ready_i,
  output mvt_pkg::vec_t  res_o,
  output logic           sat_o
);
  import mvt_pkg::*;

  logic signed [ACC_W-1:0] sum_w [DIM];
  logic signed [ACC_W-1:0] shf_w [DIM];
  logic [DIM-1:0]          clip_w;
  vec_t                    res_d, res_q;
  logic                    sat_q, valid_q, adv;

  assign adv     = !valid_q || ready_i;
  assign ready_o = adv;

  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      sum_w[r] = $signed(item_i.acc[r]) + $signed(ROUND_HALF);
      shf_w[r] = sum_w[r] >>> FRAC_BITS;
      // In range only when every bit above the result sign copies it.
      clip_w[r] = !((&shf_w[r][ACC_W-1:DATA_W-1]) || !(|shf_w[r][ACC_W-1:DATA_W-1]));
      if (clip_w[r]) begin
        res_d[r] = shf_w[r][ACC_W-1] ? SAT_MIN : SAT_MAX;
      end else begin
        res_d[r] = shf_w[r][DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i && (item_i.mode == MODE_XFORM);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      res_q <= res_d;
      sat_q <= |clip_w;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
  assign sat_o   = sat_q;

endmodule
`default_nettype wire

// ----- hw/rtl/matrix_vector_transform.sv -----
// Top level of the 4x4 fixed-point matrix vector transform unit.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------
//   input   | in        | in_valid_i / in_ready_o | mode, column_index, elem_x..elem_w
//   output  | out       | out_valid_o/out_ready_i | out_x..out_w, saturated
//
// One transaction enters per cycle while in_ready_o is high. A transform result
// passes through two stages in each column cell (multiply, then accumulate) and
// then the rounding output register.
// Every stage moves when it is empty or when the stage after it moves, so
// bubbles close up and input transactions are taken while a result waits.
// in_ready_o drops only when every stage is full and the output is stalled.
// Reset loads the identity matrix and empties the pipeline at once.
`default_nettype none
`include "matrix_vector_transform_macros.svh"
module matrix_vector_transform (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [mvt_pkg::COL_W-1:0]         column_index_i,
  input  logic signed [mvt_pkg::DATA_W-1:0] elem_x_i,
  input  logic signed [mvt_pkg::DATA_W-1:0] elem_y_i,
  input  logic signed [mvt_pkg::DATA_W-1:0] elem_z_i,
  input  logic signed [mvt_pkg::DATA_W-1:0] elem_w_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [mvt_pkg::DATA_W-1:0] out_x_o,
  output logic signed [mvt_pkg::DATA_W-1:0] out_y_o,
  output logic signed [mvt_pkg::DATA_W-1:0] out_z_o,
  output logic signed [mvt_pkg::DATA_W-1:0] out_w_o,
  output logic                              saturated_o
);
  import mvt_pkg::*;

  // Links between the cells; link 0 is the input port, link DIM feeds rounding.
  pipe_t link_item  [DIM+1];
  logic  link_valid [DIM+1];
  logic  link_ready [DIM+1];

  logic [ELEM_N-1:0][DATA_W-1:0] elems_in;
  logic [ELEM_N-1:0][DATA_W-1:0] rows_out;
  vec_t                          res;

  // Conditions used by the assertions at the end.
  logic in_stall, out_stall, sat_out, out_at_limit;

  // Elements past DIM are dropped here; they take part in nothing.
  assign elems_in = {elem_w_i, elem_z_i, elem_y_i, elem_x_i};

  always_comb begin
    link_item[0]         = '0;
    link_item[0].mode    = mode_e'(mode_i);
    link_item[0].col_idx = column_index_i;
    for (int c = 0; c < DIM; c++) begin
      link_item[0].vec[c] = elems_in[c];
    end
  end

  assign link_valid[0] = in_valid_i;
  assign in_ready_o    = link_ready[0];

  // Cell c owns matrix column c and adds column c times element c to the
  // running row sums. A load for a column that has no cell changes nothing.
  for (genvar c = 0; c < DIM; c++) begin : g_cell
    mvt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(c)),
      .valid_i    (link_valid[c]),
      .ready_o    (link_ready[c]),
      .item_i     (link_item[c]),
      .valid_o    (link_valid[c+1]),
      .ready_i    (link_ready[c+1]),
      .item_o     (link_item[c+1])
    );
  end

  // Load transactions leave the pipeline here without producing a result.
  mvt_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (link_valid[DIM]),
    .ready_o (link_ready[DIM]),
    .item_i  (link_item[DIM]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res),
    .sat_o   (saturated_o)
  );

  // Rows past DIM read as zero.
  always_comb begin
    rows_out = '0;
    for (int r = 0; r < DIM; r++) begin
      rows_out[r] = res[r];
    end
  end

  assign out_x_o = rows_out[0];
  assign out_y_o = rows_out[1];
  assign out_z_o = rows_out[2];
  assign out_w_o = rows_out[3];

  assign in_stall     = !in_ready_o;
  assign out_stall    = out_valid_o && !out_ready_i;
  assign sat_out      = out_valid_o && saturated_o;
  assign out_at_limit = (out_x_o == SAT_MAX) || (out_x_o == SAT_MIN) ||
                        (out_y_o == SAT_MAX) || (out_y_o == SAT_MIN) ||
                        (out_z_o == SAT_MAX) || (out_z_o == SAT_MIN) ||
                        (out_w_o == SAT_MAX) || (out_w_o == SAT_MIN);

  // A saturated result must carry at least one clipped element.
  `MVT_ASSERT(a_sat_has_clip, sat_out |-> out_at_limit, "saturated result, no clipped row")
  // The input is held off only by a stalled output with the pipeline full.
  `MVT_ASSERT(a_stall_cause, in_stall |-> out_stall, "input stall without output stall")
  // A full pipeline stays full across a stall, so next cycle the input
  // follows the output ready.
  `MVT_ASSERT_NEXT(a_stall_holds, in_stall, in_ready_o == out_ready_i, "stall ended early")

endmodule
`default_nettype wire
